/* design/gpts_pkg.sv */
// ----------------------------------------------------------------------------
// gpts_pkg
// Shared widths, segment codes, register indexes and types for the glottal
// pulse table sample block.
// ----------------------------------------------------------------------------
`default_nettype none

package gpts_pkg;

  localparam int IDX_W      = 8;
  localparam int LEN_W      = 9;
  localparam int PEAK_W     = 23;
  localparam int SEG_W      = 2;
  localparam int FRAC_BITS  = 24;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 23;
  localparam int Q_DEPTH    = 2;

  localparam int TABLE_DEPTH_DEF = 256;

  localparam logic [SEG_W-1:0] SEG_CLOSED = 2'd0;
  localparam logic [SEG_W-1:0] SEG_RISE   = 2'd1;
  localparam logic [SEG_W-1:0] SEG_FALL   = 2'd2;
  localparam logic [SEG_W-1:0] SEG_PAST   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_CLOSED_LEN = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_LEN   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_LEN   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_LEVEL = 4'd3;

  localparam logic [LEN_W-1:0]  CLOSED_LEN_RST = 9'd113;
  localparam logic [LEN_W-1:0]  RISE_LEN_RST   = 9'd102;
  localparam logic [LEN_W-1:0]  FALL_LEN_RST   = 9'd41;
  localparam logic [PEAK_W-1:0] PEAK_LEVEL_RST = 23'd8388607;

  typedef struct packed {
    logic [LEN_W-1:0] closed_len;
    logic [LEN_W-1:0] rise_len;
    logic [LEN_W-1:0] fall_len;
  } gpts_len_cfg_t;

  typedef struct packed {
    logic [SEG_W-1:0] seg;
    logic [LEN_W-1:0] off;
    logic [LEN_W-1:0] len;
  } gpts_item_t;

endpackage

`default_nettype wire

/* design/gpts_front.sv */
// ----------------------------------------------------------------------------
// gpts_front
// Accepts table indexes and sorts each into closed, rise, fall or past end,
// with, for rise and fall, its offset into the part and the part's length.
// ----------------------------------------------------------------------------
`default_nettype none

module gpts_front #(
  parameter int TABLE_DEPTH = gpts_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                       start,
  input  wire logic [gpts_pkg::IDX_W-1:0] in_table_index,
  input  wire gpts_pkg::gpts_len_cfg_t    len_cfg,
  input  wire logic                       q_full,
  output logic                            push,
  output gpts_pkg::gpts_item_t            item
);
  import gpts_pkg::*;

  logic [LEN_W-1:0] idx_ext;
  logic [LEN_W-1:0] off_rise;
  logic [LEN_W-1:0] off_fall;
  logic             in_range;

  assign push     = start && !q_full;
  assign idx_ext  = {{(LEN_W-IDX_W){1'b0}}, in_table_index};
  assign off_rise = idx_ext - len_cfg.closed_len;
  assign off_fall = off_rise - len_cfg.rise_len;
  assign in_range = 32'(in_table_index) < 32'(TABLE_DEPTH);

  // zero-length parts fall through naturally, since off < 0 never holds
  always_comb begin
    item.off = '0;
    item.len = '0;
    priority if (!in_range) begin
      item.seg = SEG_PAST;
    end else if (idx_ext < len_cfg.closed_len) begin
      item.seg = SEG_CLOSED;
    end else if (off_rise < len_cfg.rise_len) begin
      item.seg = SEG_RISE;
      item.off = off_rise;
      item.len = len_cfg.rise_len;
    end else if (off_fall < len_cfg.fall_len) begin
      item.seg = SEG_FALL;
      item.off = off_fall;
      item.len = len_cfg.fall_len;
    end else begin
      item.seg = SEG_PAST;
    end
  end

endmodule

`default_nettype wire

/* design/gpts_queue.sv */
// ----------------------------------------------------------------------------
// gpts_queue
// Short first-in first-out queue of classified items between the front and
// the back.
// ----------------------------------------------------------------------------
`default_nettype none

module gpts_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire gpts_pkg::gpts_item_t push_item,
  input  wire logic                 pop,
  output gpts_pkg::gpts_item_t      head_item,
  output logic                      not_empty,
  output logic                      full
);
  import gpts_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  gpts_item_t       mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(Q_DEPTH));
  assign do_pop    = pop && not_empty;
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH-1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH-1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

/* design/gpts_back.sv */
// ----------------------------------------------------------------------------
// gpts_back
// Evaluation pipeline: a restoring divider of one quotient bit per stage
// forms x, then x^2, x^3, the part's polynomial and the peak scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module gpts_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_vld,
  input  wire gpts_pkg::gpts_item_t        in_item,
  input  wire logic [gpts_pkg::PEAK_W-1:0] peak_level,
  output logic                             out_valid,
  output logic [gpts_pkg::PEAK_W-1:0]      out_sample_value,
  output logic [gpts_pkg::SEG_W-1:0]       out_segment
);
  import gpts_pkg::*;

  localparam int POLY_W   = FRAC_BITS + 1;
  localparam int WIDE_W   = 2 * FRAC_BITS;
  localparam int TAIL_LAT = FRAC_BITS + 4;
  localparam logic [POLY_W:0]   FRAC_ONE   = (POLY_W+1)'(1) << FRAC_BITS;
  localparam logic [WIDE_W-1:0] ROUND_HALF = WIDE_W'(1) << (FRAC_BITS - 1);

  // divider stages
  logic                 vld_r [FRAC_BITS];
  logic [SEG_W-1:0]     seg_r [FRAC_BITS];
  logic [LEN_W-1:0]     len_r [FRAC_BITS];
  logic [LEN_W-1:0]     rem_r [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_r [FRAC_BITS];
  logic [LEN_W-1:0]     rem_nxt [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_nxt [FRAC_BITS];

  // polynomial stages
  logic                 vld_a_r, vld_b_r, vld_c_r, vld_d_r;
  logic [SEG_W-1:0]     seg_a_r, seg_b_r, seg_c_r, seg_d_r;
  logic [FRAC_BITS-1:0] x_a_r, x2_b_r;
  logic [WIDE_W-1:0]    xx_a_r, x3p_b_r, prod_d_r;
  logic [POLY_W-1:0]    poly_c_r, poly_nxt;
  logic [POLY_W:0]      rise_raw;
  logic [WIDE_W-1:0]    xx_nxt, x3p_nxt, prod_nxt, rounded;
  logic [FRAC_BITS-1:0] x2, x3;

  always_comb begin
    for (int s = 0; s < FRAC_BITS; s++) begin
      logic [LEN_W-1:0]     rem_src;
      logic [LEN_W-1:0]     len_src;
      logic [FRAC_BITS-1:0] quo_src;
      logic [LEN_W:0]       shifted;
      logic                 ge;
      if (s == 0) begin
        rem_src = in_item.off;
        len_src = in_item.len;
        quo_src = '0;
      end else begin
        rem_src = rem_r[s-1];
        len_src = len_r[s-1];
        quo_src = quo_r[s-1];
      end
      shifted    = {rem_src, 1'b0};
      ge         = shifted >= {1'b0, len_src};
      // remainder stays below the length, so it fits back in LEN_W bits
      rem_nxt[s] = ge ? LEN_W'(shifted - {1'b0, len_src}) : shifted[LEN_W-1:0];
      quo_nxt[s] = {quo_src[FRAC_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < FRAC_BITS; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_vld;
      for (int s = 1; s < FRAC_BITS; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    seg_r[0] <= in_item.seg;
    len_r[0] <= in_item.len;
    for (int s = 1; s < FRAC_BITS; s++) begin
      seg_r[s] <= seg_r[s-1];
      len_r[s] <= len_r[s-1];
    end
    for (int s = 0; s < FRAC_BITS; s++) begin
      rem_r[s] <= rem_nxt[s];
      quo_r[s] <= quo_nxt[s];
    end
  end

  assign xx_nxt  = WIDE_W'(quo_r[FRAC_BITS-1]) * WIDE_W'(quo_r[FRAC_BITS-1]);
  assign x2      = xx_a_r[WIDE_W-1:FRAC_BITS];
  assign x3p_nxt = WIDE_W'(x2) * WIDE_W'(x_a_r);
  assign x3      = x3p_b_r[WIDE_W-1:FRAC_BITS];
  assign rise_raw = ((POLY_W+1)'(x2_b_r) << 1) + (POLY_W+1)'(x2_b_r)
                  - ((POLY_W+1)'(x3) << 1);

  always_comb begin
    unique case (seg_b_r)
      SEG_RISE: poly_nxt = (rise_raw > FRAC_ONE) ? POLY_W'(FRAC_ONE) : POLY_W'(rise_raw);
      SEG_FALL: poly_nxt = POLY_W'(FRAC_ONE) - POLY_W'(x2_b_r);
      default:  poly_nxt = '0;
    endcase
  end

  assign prod_nxt = WIDE_W'(peak_level) * WIDE_W'(poly_c_r);
  assign rounded  = prod_d_r + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r   <= 1'b0;
      vld_b_r   <= 1'b0;
      vld_c_r   <= 1'b0;
      vld_d_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld_a_r   <= vld_r[FRAC_BITS-1];
      vld_b_r   <= vld_a_r;
      vld_c_r   <= vld_b_r;
      vld_d_r   <= vld_c_r;
      out_valid <= vld_d_r;
    end
  end

  always_ff @(posedge clk) begin
    seg_a_r          <= seg_r[FRAC_BITS-1];
    x_a_r            <= quo_r[FRAC_BITS-1];
    xx_a_r           <= xx_nxt;
    seg_b_r          <= seg_a_r;
    x2_b_r           <= x2;
    x3p_b_r          <= x3p_nxt;
    seg_c_r          <= seg_b_r;
    poly_c_r         <= poly_nxt;
    seg_d_r          <= seg_c_r;
    prod_d_r         <= prod_nxt;
    out_segment      <= seg_d_r;
    out_sample_value <= rounded[FRAC_BITS+PEAK_W-1:FRAC_BITS];
  end

  a_tail_latency: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> ##TAIL_LAT out_valid)
    else $error("item entering the divider did not leave on time");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[FRAC_BITS-1] && (seg_r[FRAC_BITS-1] == SEG_RISE ||
                           seg_r[FRAC_BITS-1] == SEG_FALL)
    |-> rem_r[FRAC_BITS-1] < len_r[FRAC_BITS-1])
    else $error("divider remainder not below part length");

  a_zero_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_segment == SEG_CLOSED || out_segment == SEG_PAST)
    |-> out_sample_value == '0)
    else $error("non-zero sample outside rise and fall");

endmodule

`default_nettype wire

/* design/glottal_pulse_table_sample.sv */
// Path: an accepted index passes the queue, then 24 divider stages, then the
// x^2, x^3, polynomial, scaling and output registers, and strobes out_valid.
// Throughput: one index per cycle; the back pipeline never stalls, so the
// queue holds at most one item and busy stays low.
// Reset: synchronous, active low; clears the pipeline valid bits and the
// queue, and loads the length and peak registers with their reset values.
// ----------------------------------------------------------------------------
// glottal_pulse_table_sample
// Rosenberg glottal pulse sample for one table index, with configurable part
// lengths and peak level.
// ----------------------------------------------------------------------------
`default_nettype none

module glottal_pulse_table_sample #(
  parameter int TABLE_DEPTH = gpts_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [gpts_pkg::IDX_W-1:0]     in_table_index,
  output logic                                out_valid,
  output logic [gpts_pkg::PEAK_W-1:0]         out_sample_value,
  output logic [gpts_pkg::SEG_W-1:0]          out_segment,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gpts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [gpts_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gpts_pkg::*;

  gpts_len_cfg_t     len_cfg_r;
  logic [PEAK_W-1:0] peak_level_r;
  logic              push;
  gpts_item_t        push_item;
  gpts_item_t        head_item;
  logic              q_not_empty;
  logic              q_full;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_cfg_r.closed_len <= CLOSED_LEN_RST;
      len_cfg_r.rise_len   <= RISE_LEN_RST;
      len_cfg_r.fall_len   <= FALL_LEN_RST;
      peak_level_r         <= PEAK_LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CLOSED_LEN: len_cfg_r.closed_len <= cfg_data[LEN_W-1:0];
        REG_RISE_LEN:   len_cfg_r.rise_len   <= cfg_data[LEN_W-1:0];
        REG_FALL_LEN:   len_cfg_r.fall_len   <= cfg_data[LEN_W-1:0];
        REG_PEAK_LEVEL: peak_level_r         <= cfg_data[PEAK_W-1:0];
        default: ;
      endcase
    end
  end

  gpts_front #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_front (
    .start          (start),
    .in_table_index (in_table_index),
    .len_cfg        (len_cfg_r),
    .q_full         (q_full),
    .push           (push),
    .item           (push_item)
  );

  gpts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (q_not_empty),
    .head_item (head_item),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  gpts_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_vld           (q_not_empty),
    .in_item          (head_item),
    .peak_level       (peak_level_r),
    .out_valid        (out_valid),
    .out_sample_value (out_sample_value),
    .out_segment      (out_segment)
  );

endmodule

`default_nettype wire
